@@ rtl/amp_pkg.sv @@
package amp_pkg;

  localparam int unsigned MAX_INNER    = 1024;
  localparam int unsigned MAX_POOL_LEN = 256;
  localparam int unsigned MAX_GROUPS   = 65536;
  localparam int unsigned SAMPLE_BITS  = 16;

  localparam int unsigned SUM_W      = SAMPLE_BITS + 8;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned INNER_W    = 11;
  localparam int unsigned GROUPS_W   = 17;
  localparam int unsigned AXIS_W     = 8;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned FLAT_W     = 32;
  localparam int unsigned ELEM_OUT_W = 10;
  localparam int unsigned ENTRY_W    = SUM_W + AXIS_W + FLAT_W;
  localparam int unsigned OUT_USED_W = SAMPLE_BITS + AXIS_W + FLAT_W + ELEM_OUT_W + GROUP_W;
  localparam int unsigned TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W + 1);

  localparam logic [1:0] REG_POOL_MODE   = 2'd0;
  localparam logic [1:0] REG_POOL_LENGTH = 2'd1;
  localparam logic [1:0] REG_INNER_SIZE  = 2'd2;
  localparam logic [1:0] REG_GROUP_COUNT = 2'd3;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/axis_max_avg_pooling_top.sv @@
// Max or average pooling along one tensor axis. Samples arrive group by group, axis position
// by axis position, inner element by inner element; a per-element entry in an on-chip RAM
// holds the running maximum with its argmax, or the running sum. An item is read from the RAM,
// then modified and written back; on the last axis position it then goes on to the emit state,
// in average mode by way of a 24-step serial divider that forms sum / pool_length. Results wait
// in an output register, so a new item is taken while a result is unclaimed.
module axis_max_avg_pooling_top #(
  parameter int unsigned MAX_INNER = amp_pkg::MAX_INNER
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [amp_pkg::SAMPLE_BITS-1:0] s_axis_tdata,   // sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pooled_value, arg_axis_pos, arg_flat_index, element_index, group_index, zero pad
  output logic [amp_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic                            m_axis_tlast,   // tensor_end
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [amp_pkg::CFG_AW-1:0]      paddr,
  input  logic [amp_pkg::CFG_DW-1:0]      pwdata,
  output logic [amp_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned IdxW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned SW   = amp_pkg::SUM_W;
  localparam logic signed [SW:0] SatHi = (SW+1)'((1 << (amp_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SW:0] SatLo = -SatHi - (SW+1)'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  function automatic logic [amp_pkg::SAMPLE_BITS-1:0] sat_sample(logic signed [SW:0] v);
    logic signed [SW:0] c;
    c = v;
    if (v > SatHi) c = SatHi;
    if (v < SatLo) c = SatLo;
    return c[amp_pkg::SAMPLE_BITS-1:0];
  endfunction

  // configuration
  logic                           pool_mode_q;
  logic [amp_pkg::LEN_W-1:0]      pool_length_q;
  logic [amp_pkg::INNER_W-1:0]    inner_size_q;
  logic [amp_pkg::GROUPS_W-1:0]   group_count_q;
  logic                           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_mode_q   <= amp_pkg::MODE_MAX;
      pool_length_q <= amp_pkg::LEN_W'(1);
      inner_size_q  <= amp_pkg::INNER_W'(1);
      group_count_q <= amp_pkg::GROUPS_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        amp_pkg::REG_POOL_MODE:   pool_mode_q   <= pwdata[0];
        amp_pkg::REG_POOL_LENGTH: pool_length_q <= pwdata[amp_pkg::LEN_W-1:0];
        amp_pkg::REG_INNER_SIZE:  inner_size_q  <= pwdata[amp_pkg::INNER_W-1:0];
        amp_pkg::REG_GROUP_COUNT: group_count_q <= pwdata[amp_pkg::GROUPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      amp_pkg::REG_POOL_MODE:   prdata = amp_pkg::CFG_DW'(pool_mode_q);
      amp_pkg::REG_POOL_LENGTH: prdata = amp_pkg::CFG_DW'(pool_length_q);
      amp_pkg::REG_INNER_SIZE:  prdata = amp_pkg::CFG_DW'(inner_size_q);
      amp_pkg::REG_GROUP_COUNT: prdata = amp_pkg::CFG_DW'(group_count_q);
      default:                  prdata = '0;
    endcase
  end

  // clamped limits
  logic [amp_pkg::LEN_W-1:0]    len_c;
  logic [amp_pkg::GROUPS_W-1:0] inner_ext, inner_c, groups_c;

  assign inner_ext = amp_pkg::GROUPS_W'(inner_size_q);

  always_comb begin
    len_c = pool_length_q;
    if (pool_length_q == '0) len_c = amp_pkg::LEN_W'(1);
    else if (pool_length_q > amp_pkg::LEN_W'(amp_pkg::MAX_POOL_LEN))
      len_c = amp_pkg::LEN_W'(amp_pkg::MAX_POOL_LEN);
    inner_c = inner_ext;
    if (inner_ext == '0) inner_c = amp_pkg::GROUPS_W'(1);
    else if (inner_ext > amp_pkg::GROUPS_W'(MAX_INNER)) inner_c = amp_pkg::GROUPS_W'(MAX_INNER);
    groups_c = group_count_q;
    if (group_count_q == '0) groups_c = amp_pkg::GROUPS_W'(1);
    else if (group_count_q > amp_pkg::GROUPS_W'(amp_pkg::MAX_GROUPS))
      groups_c = amp_pkg::GROUPS_W'(amp_pkg::MAX_GROUPS);
  end

  // counters and control
  logic [1:0]                    state_q, state_d;
  logic [amp_pkg::AXIS_W-1:0]    axis_q;
  logic [IdxW-1:0]               elem_q;
  logic [amp_pkg::GROUP_W-1:0]   group_q;
  logic [amp_pkg::FLAT_W-1:0]    flat_q;
  logic [amp_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                          in_acc, out_free, upd;
  logic                          first, last_axis, last_elem, last_group;
  logic [31:0]                   elem_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign upd           = (state_q == ST_UPD);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign elem_ext      = 32'(elem_q);

  assign first      = (axis_q == '0);
  assign last_axis  = ({1'b0, axis_q} + amp_pkg::LEN_W'(1)) >= len_c;
  assign last_elem  = (amp_pkg::GROUPS_W'(elem_q) + amp_pkg::GROUPS_W'(1)) >= inner_c;
  assign last_group = ({1'b0, group_q} + amp_pkg::GROUPS_W'(1)) >= groups_c;

  // entry store and read-modify-write
  logic [amp_pkg::ENTRY_W-1:0]   rdata, wdata;
  logic signed [SW-1:0]          rd_run, s_ext, new_run;
  logic [amp_pkg::AXIS_W-1:0]    new_pos;
  logic [amp_pkg::FLAT_W-1:0]    new_flat;
  logic                          take, neg;
  logic [SW-1:0]                 abs_run;

  amp_ram #(
    .Width(amp_pkg::ENTRY_W),
    .Depth(MAX_INNER)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (upd),
    .waddr_i(elem_q),
    .wdata_i(wdata),
    .re_i   (in_acc),
    .raddr_i(elem_q),
    .rdata_o(rdata)
  );

  assign rd_run = $signed(rdata[SW-1:0]);
  assign s_ext  = $signed({{(SW - amp_pkg::SAMPLE_BITS){sample_q[amp_pkg::SAMPLE_BITS-1]}},
                           sample_q});
  assign take   = first || (s_ext > rd_run);

  always_comb begin
    new_pos  = rdata[SW +: amp_pkg::AXIS_W];
    new_flat = rdata[SW + amp_pkg::AXIS_W +: amp_pkg::FLAT_W];
    if (pool_mode_q == amp_pkg::MODE_AVG) begin
      new_run = first ? s_ext : rd_run + s_ext;
    end else if (take) begin
      new_run  = s_ext;
      new_pos  = axis_q;
      new_flat = flat_q;
    end else begin
      new_run = rd_run;
    end
  end

  assign wdata   = {new_flat, new_pos, new_run};
  assign neg     = new_run[SW-1];
  assign abs_run = neg ? (~new_run + SW'(1)) : new_run;

  // divider
  amp_pkg::div_req_t div_req;
  amp_pkg::div_rsp_t div_rsp;

  assign div_req.start    = upd && last_axis && (pool_mode_q == amp_pkg::MODE_AVG);
  assign div_req.dividend = abs_run;
  assign div_req.divisor  = len_c;

  amp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // pending result
  logic [amp_pkg::SAMPLE_BITS-1:0] pend_val_q;
  logic [amp_pkg::AXIS_W-1:0]      pend_pos_q;
  logic [amp_pkg::FLAT_W-1:0]      pend_flat_q;
  logic [amp_pkg::ELEM_OUT_W-1:0]  pend_elem_q;
  logic [amp_pkg::GROUP_W-1:0]     pend_group_q;
  logic                            pend_last_q;
  logic                            neg_q;
  logic [SW:0]                     quo_ext;

  assign quo_ext = {1'b0, div_rsp.quotient};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata;
    end
    if (upd && last_axis) begin
      neg_q        <= neg;
      pend_val_q   <= sat_sample({new_run[SW-1], new_run});
      pend_elem_q  <= elem_ext[amp_pkg::ELEM_OUT_W-1:0];
      pend_group_q <= group_q;
      pend_last_q  <= last_elem && last_group;
      if (pool_mode_q == amp_pkg::MODE_AVG) begin
        pend_pos_q  <= '0;
        pend_flat_q <= '0;
      end else begin
        pend_pos_q  <= new_pos;
        pend_flat_q <= new_flat;
      end
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      pend_val_q <= sat_sample(neg_q ? $signed(-quo_ext) : $signed(quo_ext));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_UPD;
      ST_UPD: begin
        if (!last_axis) state_d = ST_IDLE;
        else if (pool_mode_q == amp_pkg::MODE_AVG) state_d = ST_DIV;
        else state_d = ST_EMIT;
      end
      ST_DIV:  if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
      elem_q  <= '0;
      group_q <= '0;
      flat_q  <= '0;
    end else begin
      state_q <= state_d;
      if (upd) begin
        flat_q <= (last_elem && last_axis && last_group) ? '0
                                                         : flat_q + amp_pkg::FLAT_W'(1);
        if (last_elem) begin
          elem_q <= '0;
          if (last_axis) begin
            axis_q <= '0;
            if (last_group) begin
              group_q <= '0;
            end else begin
              group_q <= group_q + amp_pkg::GROUP_W'(1);
            end
          end else begin
            axis_q <= axis_q + amp_pkg::AXIS_W'(1);
          end
        end else begin
          elem_q <= elem_q + IdxW'(1);
        end
      end
    end
  end

  // output register
  logic                        out_valid_q;
  logic [amp_pkg::TDATA_W-1:0] out_data_q;
  logic                        out_last_q;
  logic                        out_load;

  assign out_load = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= amp_pkg::TDATA_W'({pend_group_q, pend_elem_q, pend_flat_q,
                                       pend_pos_q, pend_val_q});
      out_last_q <= pend_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/amp_ram.sv @@
module amp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/amp_div.sv @@
module amp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amp_pkg::div_req_t  req_i,
  output amp_pkg::div_rsp_t  rsp_o
);

  logic [amp_pkg::LEN_W-1:0]     rem_q, rem_d;
  logic [amp_pkg::SUM_W-1:0]     quo_q, quo_d;
  logic [amp_pkg::LEN_W-1:0]     dvs_q;
  logic [amp_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [amp_pkg::LEN_W:0]       rem_sh;
  logic [amp_pkg::LEN_W:0]       diff;
  logic                          fits;

  assign rem_sh = {rem_q, quo_q[amp_pkg::SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      cnt_d = amp_pkg::DIV_CNT_W'(amp_pkg::SUM_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? diff[amp_pkg::LEN_W-1:0] : rem_sh[amp_pkg::LEN_W-1:0];
      quo_d  = {quo_q[amp_pkg::SUM_W-2:0], fits};
      cnt_d  = cnt_q - amp_pkg::DIV_CNT_W'(1);
      done_d = (cnt_q == amp_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/amp_checker.sv @@
module amp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [amp_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && s_axis_tready)
    else $error("output valid or input stalled after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while previous item still in the store update");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[amp_pkg::TDATA_W-1:amp_pkg::OUT_USED_W] == '0)
    else $error("padding bits of result not zero");

endmodule

bind axis_max_avg_pooling_top amp_checker u_amp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

@@ dv/testbench.sv @@
module testbench;
  import amp_pkg::*;

  localparam int unsigned POS_LO  = SAMPLE_BITS;
  localparam int unsigned FLAT_LO = POS_LO + AXIS_W;
  localparam int unsigned ELEM_LO = FLAT_LO + FLAT_W;
  localparam int unsigned GRP_LO  = ELEM_LO + ELEM_OUT_W;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned ITEM_TARGET  = 850;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [AXIS_W-1:0]             axis_pos;
    logic [FLAT_W-1:0]             flat_idx;
    logic [ELEM_OUT_W-1:0]         elem;
    logic [GROUP_W-1:0]            group;
    logic                          tensor_end;
  } pool_result_t;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  class pool_column_tracker;
    logic                mode;
    logic [LEN_W-1:0]    pool_len;
    logic [INNER_W-1:0]  inner_sz;
    logic [GROUPS_W-1:0] group_lim;
    longint              column_acc[MAX_INNER];
    logic [AXIS_W-1:0]   best_pos[MAX_INNER];
    logic [FLAT_W-1:0]   best_flat[MAX_INNER];
    int unsigned         axis_cnt;
    int unsigned         elem_cnt;
    int unsigned         group_cnt;
    logic [FLAT_W-1:0]   flat_cnt;
    pool_result_t        pending_pools[$];
    int unsigned         errors;

    function new();
      mode      = MODE_MAX;
      pool_len  = LEN_W'(1);
      inner_sz  = INNER_W'(1);
      group_lim = GROUPS_W'(1);
      axis_cnt  = 0;
      elem_cnt  = 0;
      group_cnt = 0;
      flat_cnt  = '0;
      errors    = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_POOL_MODE:   mode      = data[0];
        REG_POOL_LENGTH: pool_len  = data[LEN_W-1:0];
        REG_INNER_SIZE:  inner_sz  = data[INNER_W-1:0];
        REG_GROUP_COUNT: group_lim = data[GROUPS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] raw);
      int unsigned  len, inner, groups, e;
      longint       s, v, smax, smin;
      bit           first, last_axis, last_elem, last_group;
      pool_result_t r;
      len        = clamp_to(pool_len, 1, MAX_POOL_LEN);
      inner      = clamp_to(inner_sz, 1, MAX_INNER);
      groups     = clamp_to(group_lim, 1, MAX_GROUPS);
      s          = longint'($signed(raw));
      smax       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      smin       = -smax - 1;
      e          = elem_cnt % MAX_INNER;
      first      = (axis_cnt == 0);
      last_axis  = (axis_cnt + 1 >= len);
      last_elem  = (elem_cnt + 1 >= inner);
      last_group = (group_cnt + 1 >= groups);

      if (mode == MODE_MAX) begin
        if (first || s > column_acc[e]) begin
          column_acc[e] = s;
          best_pos[e]   = AXIS_W'(axis_cnt);
          best_flat[e]  = flat_cnt;
        end
      end else begin
        column_acc[e] = first ? s : column_acc[e] + s;
      end

      if (last_axis) begin
        v          = column_acc[e];
        r.axis_pos = '0;
        r.flat_idx = '0;
        if (mode == MODE_MAX) begin
          r.axis_pos = best_pos[e];
          r.flat_idx = best_flat[e];
        end else begin
          v = v / longint'(len);
        end
        if (v > smax) v = smax;
        if (v < smin) v = smin;
        r.value      = v[SAMPLE_BITS-1:0];
        r.elem       = ELEM_OUT_W'(elem_cnt);
        r.group      = GROUP_W'(group_cnt);
        r.tensor_end = last_elem && last_group;
        pending_pools = {pending_pools, r};
      end

      flat_cnt = flat_cnt + 1;
      if (last_elem) begin
        elem_cnt = 0;
        if (last_axis) begin
          axis_cnt = 0;
          if (last_group) begin
            group_cnt = 0;
            flat_cnt  = '0;
          end else begin
            group_cnt++;
          end
        end else begin
          axis_cnt++;
        end
      end else begin
        elem_cnt++;
      end
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pool(logic [TDATA_W-1:0] data, logic last);
      pool_result_t want;
      if (pending_pools.size() == 0) begin
        $error("result with nothing expected: tdata=%h tlast=%b", data, last);
        errors++;
        return;
      end
      want = pending_pools.pop_front();
      check_field("pooled_value", longint'(want.value),
                  longint'($signed(data[SAMPLE_BITS-1:0])));
      check_field("arg_axis_pos", longint'(want.axis_pos), longint'(data[POS_LO +: AXIS_W]));
      check_field("arg_flat_index", longint'(want.flat_idx),
                  longint'(data[FLAT_LO +: FLAT_W]));
      check_field("element_index", longint'(want.elem), longint'(data[ELEM_LO +: ELEM_OUT_W]));
      check_field("group_index", longint'(want.group), longint'(data[GRP_LO +: GROUP_W]));
      check_field("tensor_end", longint'(want.tensor_end), longint'(last));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]     m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [CFG_AW-1:0]      paddr         = '0;
  logic [CFG_DW-1:0]      pwdata        = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  pool_column_tracker tracker = new();
  int unsigned items_sent  = 0;
  int unsigned send_idle   = 11;
  int unsigned recv_idle   = 59;
  int unsigned long_phases = 0;

  axis_max_avg_pooling_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_pool(m_axis_tdata, m_axis_tlast);
      if (psel && penable && pwrite && pready) tracker.set_register(paddr[CFG_AW-1:2], pwdata);
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_pools.size() != 0);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic program_pool(input logic [CFG_DW-1:0] mode, input logic [CFG_DW-1:0] len,
                              input logic [CFG_DW-1:0] inner, input logic [CFG_DW-1:0] groups);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write(REG_POOL_MODE, mode);
    apb_write(REG_POOL_LENGTH, len);
    apb_write(REG_INNER_SIZE, inner);
    apb_write(REG_GROUP_COUNT, groups);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle = 11;
      recv_idle = 59;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle = 59;
      recv_idle = 11;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic feed_samples(input logic [SAMPLE_BITS-1:0] q[$], input int hold_at);
    foreach (q[i]) begin
      if (i == hold_at) wait_drained();
      send_sample(q[i]);
    end
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(15))
      0:       v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2, 3, 4: begin
        // narrow range so that ties show up
        v = SAMPLE_BITS'($urandom_range(4));
        v = v - SAMPLE_BITS'(2);
      end
      default: v = SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1));
    endcase
    return v;
  endfunction

  task automatic random_phase(input bit force_long, input bit hold);
    logic [CFG_DW-1:0]      mode, len_raw, inner_raw, grp_raw;
    logic [SAMPLE_BITS-1:0] samples[$];
    int unsigned            kind, n_groups, n_items;
    bit                     partial;
    kind     = force_long ? 0 : $urandom_range(9);
    if (kind == 0 && long_phases >= 2) kind = 5;
    mode     = $urandom_range(1);
    partial  = 1'b0;
    n_groups = $urandom_range(1, 4);
    case (kind)
      0: begin
        len_raw   = $urandom_range(1) ? MAX_POOL_LEN : $urandom_range(MAX_POOL_LEN + 1, 511);
        inner_raw = 1;
        grp_raw   = $urandom_range(1, 3);
        n_groups  = 1;
        long_phases++;
      end
      1: begin
        // one axis position only, so a partial group leaves no stale entries
        len_raw   = 1;
        inner_raw = $urandom_range(1) ? MAX_INNER : $urandom_range(MAX_INNER + 1, 2047);
        grp_raw   = $urandom_range(1) ? MAX_GROUPS : $urandom_range(2**GROUPS_W - 1);
        partial   = 1'b1;
      end
      2: begin
        len_raw   = $urandom_range(2);
        inner_raw = $urandom_range(2);
        grp_raw   = $urandom_range(2);
      end
      default: begin
        len_raw   = $urandom_range(1, 8);
        inner_raw = $urandom_range(1, 6);
        grp_raw   = $urandom_range(1, 5);
      end
    endcase
    n_items = partial ? $urandom_range(20, 80)
                      : n_groups * clamp_to(len_raw, 1, MAX_POOL_LEN)
                        * clamp_to(inner_raw, 1, MAX_INNER);
    repeat (n_items) samples = {samples, pick_sample()};
    program_pool(mode, len_raw, inner_raw, grp_raw);
    feed_samples(samples, hold ? int'(n_items / 2) : -1);
    if (partial) begin
      // single-item tensor wraps every counter back to zero
      program_pool(mode, 1, 1, 1);
      send_sample(pick_sample());
    end
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [SAMPLE_BITS-1:0] q[$];
    int unsigned            phase_no;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every sample is its own tensor
    q = {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    feed_samples(q, -1);

    // max with ties, then shrink group_count past the group counter
    program_pool(MODE_MAX, 3, 2, 3);
    q = {16'h8000, 16'h0005, 16'h8000, 16'h0007, 16'h0064, 16'h0007};
    feed_samples(q, -1);
    program_pool(MODE_MAX, 3, 2, 1);
    q = {16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF};
    feed_samples(q, -1);

    // average truncates toward zero
    program_pool(MODE_AVG, 2, 2, 1);
    q = {16'h8000, 16'h0001, 16'h8001, 16'hFFFE};
    feed_samples(q, -1);

    // zero lengths act as one
    program_pool(MODE_AVG, 0, 0, 0);
    q = {16'h3039};
    feed_samples(q, -1);

    // oversized lengths clamp; partial group then forced wrap
    program_pool(MODE_MAX, 1, 2047, 2**GROUPS_W - 1);
    q = {16'h0001, 16'hFFFF, 16'h1234};
    feed_samples(q, -1);
    program_pool(MODE_AVG, 1, 1, 1);
    q = {16'h8000};
    feed_samples(q, -1);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase_no == 1, phase_no == 2);
      phase_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending_pools.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending_pools.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/amp_pkg.sv
rtl/amp_ram.sv
rtl/amp_div.sv
rtl/axis_max_avg_pooling_top.sv
rtl/amp_checker.sv
dv/testbench.sv
